[rtl/sopll_pkg.sv]
// ----------------------------------------------------------------------------
// sopll_pkg
// Shared constants, CORDIC angle table and control types for the PLL.
// ----------------------------------------------------------------------------
`default_nettype none

package sopll_pkg;

	localparam int SAMPLE_WIDTH_DEF  = 16;
	localparam int ANGLE_WIDTH_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int GAIN_WIDTH        = 17;
	localparam int CFG_INDEX_WIDTH   = 3;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALPHA      = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BETA       = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_FREQ   = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_FREQ   = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INIT_PHASE = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INIT_FREQ  = 3'd5;

	localparam logic [GAIN_WIDTH-1:0] ALPHA_RESET = 17'd915;
	localparam logic [GAIN_WIDTH-1:0] BETA_RESET  = 17'd13;

	// CORDIC gain 0.60725 in 32-bit fraction
	localparam logic [33:0] CORDIC_K32 = 34'h09B74EDA8;

	typedef struct packed {
		logic ld_phase;
		logic ld_freq;
	} loop_load_t;

	// atan(2^-i) as a fraction of a turn, 32 bits
	function automatic logic [31:0] atan_turn(input int idx);
		logic [31:0] t;
		t = 32'h0;
		unique case (idx)
			0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
			3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
			9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
			12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
			15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
			18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
			21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
			24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
			27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
			30: t = 32'h00000001;
			default: t = 32'h0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

[rtl/sopll_vec_cell.sv]
// ----------------------------------------------------------------------------
// sopll_vec_cell
// One vectoring CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sopll_vec_cell #(
	parameter int W   = 19,
	parameter int IDX = 0
) (
	input  wire               clk,
	input  wire               en,
	input  wire signed [W-1:0] x_in,
	input  wire signed [W-1:0] y_in,
	input  wire        [31:0]  z_in,
	output logic signed [W-1:0] x_q,
	output logic signed [W-1:0] y_q,
	output logic        [31:0]  z_q
);

	localparam logic [31:0] ATAN = sopll_pkg::atan_turn(IDX);

	logic signed [W-1:0] dx, dy;

	assign dx = y_in >>> IDX;
	assign dy = x_in >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[W-1]) begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + ATAN;
			end else begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - ATAN;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/sopll_rot_cell.sv]
// ----------------------------------------------------------------------------
// sopll_rot_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sopll_rot_cell #(
	parameter int W   = 18,
	parameter int IDX = 0
) (
	input  wire               clk,
	input  wire               en,
	input  wire signed [W-1:0] x_in,
	input  wire signed [W-1:0] y_in,
	input  wire        [31:0]  z_in,
	output logic signed [W-1:0] x_q,
	output logic signed [W-1:0] y_q,
	output logic        [31:0]  z_q
);

	localparam logic [31:0] ATAN = sopll_pkg::atan_turn(IDX);

	logic signed [W-1:0] dx, dy;

	assign dx = y_in >>> IDX;
	assign dy = x_in >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[31]) begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - ATAN;
			end else begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + ATAN;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/sopll_loop.sv]
// ----------------------------------------------------------------------------
// sopll_loop
// PI loop filter and NCO accumulators: phase error, clamped frequency, phase.
// ----------------------------------------------------------------------------
`default_nettype none

module sopll_loop #(
	parameter int AW = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   en,
	input  wire                                   upd,
	input  wire  [AW-1:0]                         ang,
	input  wire  [sopll_pkg::GAIN_WIDTH-1:0]      alpha,
	input  wire  [sopll_pkg::GAIN_WIDTH-1:0]      beta,
	input  wire signed [AW-1:0]                   min_freq,
	input  wire signed [AW-1:0]                   max_freq,
	input  wire sopll_pkg::loop_load_t            load,
	input  wire  [AW-1:0]                         load_val,
	output logic signed [AW-1:0]                  err_q,
	output logic signed [AW-1:0]                  freq_out_q,
	output logic [AW-1:0]                         old_phase_q
);

	localparam int PW = sopll_pkg::GAIN_WIDTH + 1 + AW;
	localparam int GW = PW - 15;

	logic [AW-1:0]        phase_q;
	logic signed [AW-1:0] freq_q;
	logic signed [AW-1:0] err;
	logic signed [PW-1:0] prod_a, prod_b;
	logic signed [GW-1:0] gain_a, gain_b;
	logic signed [GW:0]   fsum;
	logic signed [AW-1:0] fclamp;
	logic [AW-1:0]        phase_nxt;

	assign err = signed'(ang - phase_q);
	assign prod_a = PW'(signed'({1'b0, alpha})) * PW'(err);
	assign prod_b = PW'(signed'({1'b0, beta})) * PW'(err);
	assign gain_a = GW'((prod_a + PW'(16384)) >>> 15);
	assign gain_b = GW'((prod_b + PW'(16384)) >>> 15);
	assign fsum = (GW+1)'(freq_q) + (GW+1)'(gain_b);

	always_comb begin
		priority if (fsum > (GW+1)'(max_freq)) begin
			fclamp = max_freq;
		end else if (fsum < (GW+1)'(min_freq)) begin
			fclamp = min_freq;
		end else begin
			fclamp = AW'(fsum);
		end
	end

	assign phase_nxt = phase_q + fclamp + AW'(gain_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			freq_q  <= '0;
		end else begin
			if (load.ld_phase) begin
				phase_q <= load_val;
			end else if (en && upd) begin
				phase_q <= phase_nxt;
			end
			if (load.ld_freq) begin
				freq_q <= load_val;
			end else if (en && upd) begin
				freq_q <= fclamp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_q       <= err;
			freq_out_q  <= fclamp;
			old_phase_q <= phase_q;
		end
	end

endmodule

`default_nettype wire

[rtl/second_order_phase_locked_loop.sv]
// ----------------------------------------------------------------------------
// second_order_phase_locked_loop
// Digital PLL: CORDIC phase detector, PI loop filter, CORDIC sin/cos NCO.
// ----------------------------------------------------------------------------
// Input stream s_*: one complex sample per transfer, tdata = {quadrature, in_phase}.
// Output stream m_*: one result per sample, tdata = {freq_estimate, phase_error,
// nco_sin, nco_cos}; cos/sin are of the NCO phase before that sample's update.
// Config channel cfg_*: register index and data, always ready; write only while
// the pipeline is empty. Writing init_phase/init_freq also loads the NCO.
// Throughput: one sample per cycle when not stalled. The whole pipeline is a chain
// of registered CORDIC cells (vectoring in front, rotation after) around a
// registered loop update; it advances as a unit whenever the output register is
// empty or taken. When the receiver stalls the pipeline holds and s_tready drops.
// Reset: gains and clamps to defaults, NCO phase and frequency to zero, pipeline
// emptied.
`default_nettype none

module second_order_phase_locked_loop #(
	parameter int SAMPLE_WIDTH  = sopll_pkg::SAMPLE_WIDTH_DEF,
	parameter int ANGLE_WIDTH   = sopll_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STAGES = sopll_pkg::CORDIC_STAGES_DEF,
	localparam int IN_W  = ((2*SAMPLE_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((2*SAMPLE_WIDTH + 2*ANGLE_WIDTH + 7) / 8) * 8,
	localparam int CFG_W = (ANGLE_WIDTH > sopll_pkg::GAIN_WIDTH) ? ANGLE_WIDTH
		: sopll_pkg::GAIN_WIDTH
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	input  wire  [IN_W-1:0]                       s_tdata,  // in_phase, quadrature
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	output logic [OUT_W-1:0]                      m_tdata,  // nco_cos, nco_sin, phase_error, freq_estimate
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [sopll_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire  [CFG_W-1:0]                      cfg_data
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int AW = ANGLE_WIDTH;
	localparam int N  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int VW = SW + 3;
	localparam int RW = SW + 2;
	localparam logic [32:0] HALF = 33'(64'd1 << (32 - AW)) >> 1;
	localparam logic [33:0] XSUM = sopll_pkg::CORDIC_K32 + (34'd1 << (32 - SW));
	localparam logic signed [RW-1:0] X0 = RW'(XSUM >> (33 - SW));
	localparam logic signed [RW-1:0] SMAX = RW'((64'd1 << (SW - 1)) - 64'd1);
	localparam logic signed [RW-1:0] SMIN = -SMAX - RW'(1);

	logic en;

	// config registers
	logic [sopll_pkg::GAIN_WIDTH-1:0] alpha_q, beta_q;
	logic signed [AW-1:0]             minf_q, maxf_q;
	sopll_pkg::loop_load_t            load;
	logic                             cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign load.ld_phase = cfg_we && (cfg_index == sopll_pkg::REG_INIT_PHASE);
	assign load.ld_freq  = cfg_we && (cfg_index == sopll_pkg::REG_INIT_FREQ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= sopll_pkg::ALPHA_RESET;
			beta_q  <= sopll_pkg::BETA_RESET;
			minf_q  <= {1'b1, {(AW-1){1'b0}}};
			maxf_q  <= {1'b0, {(AW-1){1'b1}}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				sopll_pkg::REG_ALPHA:    alpha_q <= cfg_data[sopll_pkg::GAIN_WIDTH-1:0];
				sopll_pkg::REG_BETA:     beta_q  <= cfg_data[sopll_pkg::GAIN_WIDTH-1:0];
				sopll_pkg::REG_MIN_FREQ: minf_q  <= cfg_data[AW-1:0];
				sopll_pkg::REG_MAX_FREQ: maxf_q  <= cfg_data[AW-1:0];
				default: ;
			endcase
		end
	end

	// pipeline advance
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// vectoring chain
	logic signed [VW-1:0] vx [0:N];
	logic signed [VW-1:0] vy [0:N];
	logic [31:0]          vz [0:N];
	logic                 vzero_q [0:N];
	logic                 vv_q [0:N];
	logic signed [VW-1:0] ix, qy;

	assign ix = VW'(signed'(s_tdata[SW-1:0]));
	assign qy = VW'(signed'(s_tdata[2*SW-1:SW]));

	always_ff @(posedge clk) begin
		if (en) begin
			vzero_q[0] <= (ix == '0) && (qy == '0);
			if (ix[VW-1]) begin
				vx[0] <= -ix;
				vy[0] <= -qy;
				vz[0] <= 32'h80000000;
			end else begin
				vx[0] <= ix;
				vy[0] <= qy;
				vz[0] <= 32'h0;
			end
		end
	end

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_vec
			sopll_vec_cell #(.W(VW), .IDX(k)) u_cell (
				.clk  (clk),
				.en   (en),
				.x_in (vx[k]),
				.y_in (vy[k]),
				.z_in (vz[k]),
				.x_q  (vx[k+1]),
				.y_q  (vy[k+1]),
				.z_q  (vz[k+1])
			);
			always_ff @(posedge clk) begin
				if (en) begin
					vzero_q[k+1] <= vzero_q[k];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= N; i++) vv_q[i] <= 1'b0;
		end else if (en) begin
			vv_q[0] <= s_tvalid;
			for (int i = 1; i <= N; i++) vv_q[i] <= vv_q[i-1];
		end
	end

	// angle rounding
	logic [32:0]   zsum;
	logic [AW-1:0] ang;

	assign zsum = {1'b0, vz[N]} + HALF;
	assign ang  = vzero_q[N] ? '0 : zsum[31 -: AW];

	// loop update
	logic signed [AW-1:0] err_l, freq_l;
	logic [AW-1:0]        oph_l;
	logic                 lv_q;

	sopll_loop #(.AW(AW)) u_loop (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.upd         (vv_q[N]),
		.ang         (ang),
		.alpha       (alpha_q),
		.beta        (beta_q),
		.min_freq    (minf_q),
		.max_freq    (maxf_q),
		.load        (load),
		.load_val    (cfg_data[AW-1:0]),
		.err_q       (err_l),
		.freq_out_q  (freq_l),
		.old_phase_q (oph_l)
	);

	// rotation chain
	logic signed [RW-1:0] rx [0:N];
	logic signed [RW-1:0] ry [0:N];
	logic [31:0]          rz [0:N];
	logic                 rflip_q [0:N];
	logic [AW-1:0]        rerr_q [0:N];
	logic [AW-1:0]        rfreq_q [0:N];
	logic                 rv_q [0:N];
	logic [31:0]          pz;
	logic                 pflip;

	assign pz    = 32'(oph_l) << (32 - AW);
	assign pflip = (pz > 32'h40000000) && (pz < 32'hC0000000);

	always_ff @(posedge clk) begin
		if (en) begin
			rx[0]      <= X0;
			ry[0]      <= '0;
			rz[0]      <= pflip ? (pz ^ 32'h80000000) : pz;
			rflip_q[0] <= pflip;
			rerr_q[0]  <= err_l;
			rfreq_q[0] <= freq_l;
		end
	end

	generate
		for (k = 0; k < N; k++) begin : g_rot
			sopll_rot_cell #(.W(RW), .IDX(k)) u_cell (
				.clk  (clk),
				.en   (en),
				.x_in (rx[k]),
				.y_in (ry[k]),
				.z_in (rz[k]),
				.x_q  (rx[k+1]),
				.y_q  (ry[k+1]),
				.z_q  (rz[k+1])
			);
			always_ff @(posedge clk) begin
				if (en) begin
					rflip_q[k+1] <= rflip_q[k];
					rerr_q[k+1]  <= rerr_q[k];
					rfreq_q[k+1] <= rfreq_q[k];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_q <= 1'b0;
			for (int i = 0; i <= N; i++) rv_q[i] <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			lv_q    <= vv_q[N];
			rv_q[0] <= lv_q;
			for (int i = 1; i <= N; i++) rv_q[i] <= rv_q[i-1];
			m_tvalid <= rv_q[N];
		end
	end

	// output: undo half-turn fold, saturate
	logic signed [RW-1:0] cx, sy, cs, ss;

	assign cx = rflip_q[N] ? -rx[N] : rx[N];
	assign sy = rflip_q[N] ? -ry[N] : ry[N];
	assign cs = (cx > SMAX) ? SMAX : ((cx < SMIN) ? SMIN : cx);
	assign ss = (sy > SMAX) ? SMAX : ((sy < SMIN) ? SMIN : sy);

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= OUT_W'({rfreq_q[N], rerr_q[N], ss[SW-1:0], cs[SW-1:0]});
		end
	end

	// loop stage hands its item to the rotation chain
	a_loop_to_rot: assert property (@(posedge clk) disable iff (!arst_n)
		(en && lv_q) |=> rv_q[0])
		else $error("loop result dropped before rotation chain");

	// end of the rotation chain always lands in the output register
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(en && rv_q[N]) |=> m_tvalid)
		else $error("rotation chain result lost at output");

	// with ordered clamps the updated frequency stays inside them
	a_freq_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vv_q[N] && (minf_q <= maxf_q) && !cfg_we)
		|=> (freq_l >= $past(minf_q)) && (freq_l <= $past(maxf_q)))
		else $error("frequency outside clamp range");

endmodule

`default_nettype wire
